// File: hw/rtl/kpe_pkg.sv
// shared types, constants and codes for the kronecker product engine
package kpe_pkg;

  // default store dimensions
  localparam int MAX_DIM_A_DEF = 16;
  localparam int MAX_DIM_B_DEF = 16;

  // queue depths
  localparam int MID_DEPTH = 2;
  localparam int RES_DEPTH = 4;

  // field widths
  localparam int IDX_W  = 4;
  localparam int DIM_W  = 5;
  localparam int VAL_W  = 32;
  localparam int ACC_W  = 64;
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 5;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_ROWS_A    = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_COLS_A    = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_ROWS_B    = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_COLS_B    = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_OVERWRITE = 3'd4;

  // command codes of an input item
  localparam logic [1:0] CMD_WR_A    = 2'd0;
  localparam logic [1:0] CMD_WR_B    = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SAT   = 2'd1;
  localparam logic [1:0] STATUS_INDEX = 2'd2;

  // operation after classification
  typedef enum logic [1:0] {
    OP_WR_A,
    OP_WR_B,
    OP_CALC,
    OP_ERR
  } op_e;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [IDX_W-1:0]        a_row;
    logic [IDX_W-1:0]        a_col;
    logic [IDX_W-1:0]        b_row;
    logic [IDX_W-1:0]        b_col;
    logic signed [VAL_W-1:0] value;
    logic signed [ACC_W-1:0] prior;
  } in_item_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] sum;
    logic [1:0]              status;
  } out_item_t;

  typedef struct packed {
    op_e                     op;
    logic [IDX_W-1:0]        a_row;
    logic [IDX_W-1:0]        a_col;
    logic [IDX_W-1:0]        b_row;
    logic [IDX_W-1:0]        b_col;
    logic signed [VAL_W-1:0] value;
    logic signed [ACC_W-1:0] prior;
  } mid_item_t;

  typedef struct packed {
    logic [DIM_W-1:0] rows_a;
    logic [DIM_W-1:0] cols_a;
    logic [DIM_W-1:0] rows_b;
    logic [DIM_W-1:0] cols_b;
    logic             overwrite;
  } cfg_t;

endpackage

// File: hw/rtl/kpe_fifo.sv
// small register queue with first-word fall-through
module kpe_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: hw/rtl/kpe_front.sv
// front end: index checks and classification of accepted items
module kpe_front #(
  parameter int MAX_DIM_A = kpe_pkg::MAX_DIM_A_DEF,
  parameter int MAX_DIM_B = kpe_pkg::MAX_DIM_B_DEF
) (
  input  logic                valid_i,
  input  kpe_pkg::in_item_t   item_i,
  input  kpe_pkg::cfg_t       cfg_i,
  output logic                push_o,
  output kpe_pkg::mid_item_t  item_o
);
  import kpe_pkg::*;

  logic ok_a, ok_b;
  logic keep;
  op_e  op;

  // an index counts only below both the register and the store size
  assign ok_a = ({1'b0, item_i.a_row} < cfg_i.rows_a) && (32'(item_i.a_row) < MAX_DIM_A)
             && ({1'b0, item_i.a_col} < cfg_i.cols_a) && (32'(item_i.a_col) < MAX_DIM_A);
  assign ok_b = ({1'b0, item_i.b_row} < cfg_i.rows_b) && (32'(item_i.b_row) < MAX_DIM_B)
             && ({1'b0, item_i.b_col} < cfg_i.cols_b) && (32'(item_i.b_col) < MAX_DIM_B);

  // classify; dropped loads and the unused code never reach the queue
  always_comb begin
    op   = OP_ERR;
    keep = 1'b0;
    case (item_i.cmd)
      CMD_WR_A: begin
        op   = OP_WR_A;
        keep = ok_a;
      end
      CMD_WR_B: begin
        op   = OP_WR_B;
        keep = ok_b;
      end
      CMD_COMPUTE: begin
        op   = (ok_a && ok_b) ? OP_CALC : OP_ERR;
        keep = 1'b1;
      end
      default: begin
        op   = OP_ERR;
        keep = 1'b0;
      end
    endcase
  end

  assign push_o       = valid_i && keep;
  assign item_o.op    = op;
  assign item_o.a_row = item_i.a_row;
  assign item_o.a_col = item_i.a_col;
  assign item_o.b_row = item_i.b_row;
  assign item_o.b_col = item_i.b_col;
  assign item_o.value = item_i.value;
  assign item_o.prior = item_i.prior;

endmodule

// File: hw/rtl/kpe_back.sv
// back end: element stores, multiply and saturating add
module kpe_back #(
  parameter int MAX_DIM_A = kpe_pkg::MAX_DIM_A_DEF,
  parameter int MAX_DIM_B = kpe_pkg::MAX_DIM_B_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               overwrite_i,
  input  logic               mid_empty_i,
  input  kpe_pkg::mid_item_t mid_item_i,
  output logic               mid_pop_o,
  input  logic               res_pop_i,
  output logic               res_push_o,
  output kpe_pkg::out_item_t res_item_o
);
  import kpe_pkg::*;

  localparam int DEPTH_A = MAX_DIM_A * MAX_DIM_A;
  localparam int DEPTH_B = MAX_DIM_B * MAX_DIM_B;
  localparam int AW_A    = (DEPTH_A > 1) ? $clog2(DEPTH_A) : 1;
  localparam int AW_B    = (DEPTH_B > 1) ? $clog2(DEPTH_B) : 1;
  localparam int UW      = $clog2(RES_DEPTH + 1);

  logic signed [VAL_W-1:0] a_mem_q [DEPTH_A];
  logic signed [VAL_W-1:0] b_mem_q [DEPTH_B];
  logic [AW_A-1:0]         a_addr;
  logic [AW_B-1:0]         b_addr;

  logic [UW-1:0]           used_q, used_d;
  logic                    has_res, credit_ok, issue, issue_res;

  logic                    s1_vld_q, s1_err_q;
  logic signed [VAL_W-1:0] s1_a_q, s1_b_q;
  logic signed [ACC_W-1:0] s1_base_q;
  logic                    s2_vld_q, s2_err_q;
  logic signed [ACC_W-1:0] s2_prod_q, s2_base_q;
  logic signed [ACC_W-1:0] prod, sum;
  logic                    ovf_pos, ovf_neg;

  // store addresses, row-major at the full store width
  assign a_addr = AW_A'(32'(mid_item_i.a_row) * MAX_DIM_A + 32'(mid_item_i.a_col));
  assign b_addr = AW_B'(32'(mid_item_i.b_row) * MAX_DIM_B + 32'(mid_item_i.b_col));

  // issue control: result items need a slot reserved in the result queue
  assign has_res   = (mid_item_i.op == OP_CALC) || (mid_item_i.op == OP_ERR);
  assign credit_ok = (used_q < UW'(RES_DEPTH)) || res_pop_i;
  assign issue     = !mid_empty_i && (!has_res || credit_ok);
  assign issue_res = issue && has_res;
  assign mid_pop_o = issue;

  always_comb begin
    used_d = used_q;
    if (issue_res && !res_pop_i) begin
      used_d = used_q + 1'b1;
    end else if (res_pop_i && !issue_res) begin
      used_d = used_q - 1'b1;
    end
  end

  // element stores: write port
  always_ff @(posedge clk_i) begin
    if (issue && (mid_item_i.op == OP_WR_A)) begin
      a_mem_q[a_addr] <= mid_item_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue && (mid_item_i.op == OP_WR_B)) begin
      b_mem_q[b_addr] <= mid_item_i.value;
    end
  end

  // element stores: registered read port
  always_ff @(posedge clk_i) begin
    if (issue && (mid_item_i.op == OP_CALC)) begin
      s1_a_q <= a_mem_q[a_addr];
      s1_b_q <= b_mem_q[b_addr];
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (issue_res) begin
      s1_err_q  <= (mid_item_i.op == OP_ERR);
      s1_base_q <= overwrite_i ? '0 : mid_item_i.prior;
    end
    if (s1_vld_q) begin
      s2_err_q  <= s1_err_q;
      s2_base_q <= s1_base_q;
      s2_prod_q <= prod;
    end
  end

  // stage valids and slot count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      used_q   <= '0;
    end else begin
      s1_vld_q <= issue_res;
      s2_vld_q <= s1_vld_q;
      used_q   <= used_d;
    end
  end

  // exact q16.16 by q16.16 product, operands sign-extended
  assign prod = ACC_W'(s1_a_q) * ACC_W'(s1_b_q);

  // saturating add
  assign sum     = s2_base_q + s2_prod_q;
  assign ovf_pos = !s2_base_q[ACC_W-1] && !s2_prod_q[ACC_W-1] && sum[ACC_W-1];
  assign ovf_neg = s2_base_q[ACC_W-1] && s2_prod_q[ACC_W-1] && !sum[ACC_W-1];

  always_comb begin
    res_item_o.sum    = sum;
    res_item_o.status = STATUS_OK;
    if (s2_err_q) begin
      res_item_o.sum    = '0;
      res_item_o.status = STATUS_INDEX;
    end else if (ovf_pos) begin
      res_item_o.sum    = {1'b0, {(ACC_W-1){1'b1}}};
      res_item_o.status = STATUS_SAT;
    end else if (ovf_neg) begin
      res_item_o.sum    = {1'b1, {(ACC_W-1){1'b0}}};
      res_item_o.status = STATUS_SAT;
    end
  end

  assign res_push_o = s2_vld_q;

endmodule

// File: hw/rtl/kronecker_product_engine.sv
// top level of the kronecker product element engine
// a compute item passes the mid queue, stage registers s1 and s2 and the result queue
// throughput: one item per cycle if no stall; loads cause no result, computes one result
// the stores have one write and one registered read port each, so one item issues a cycle
// 4-item result queue; issue waits to reserve a slot, so the back pipeline never stalls
// reset: sizes 1, overwrite 1, queues empty; element stores are not cleared
module kronecker_product_engine #(
  parameter int MAX_DIM_A = kpe_pkg::MAX_DIM_A_DEF,
  parameter int MAX_DIM_B = kpe_pkg::MAX_DIM_B_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  input  kpe_pkg::in_item_t             in_item_i,
  output logic                          full,
  output logic                          empty,
  input  logic                          pop,
  output kpe_pkg::out_item_t            out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [kpe_pkg::CFG_IW-1:0]    cfg_index_i,
  input  logic [kpe_pkg::CFG_DW-1:0]    cfg_data_i
);
  import kpe_pkg::*;

  localparam int MID_W = $bits(mid_item_t);
  localparam int RES_W = $bits(out_item_t);

  cfg_t       cfg_q, cfg_d;
  logic       front_push;
  mid_item_t  front_item;
  logic       mid_empty, mid_pop;
  logic [MID_W-1:0] mid_data;
  logic       res_push, res_full;
  out_item_t  res_item;
  logic [RES_W-1:0] res_data;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ROWS_A:    cfg_d.rows_a    = cfg_data_i;
        CFG_COLS_A:    cfg_d.cols_a    = cfg_data_i;
        CFG_ROWS_B:    cfg_d.rows_b    = cfg_data_i;
        CFG_COLS_B:    cfg_d.cols_b    = cfg_data_i;
        CFG_OVERWRITE: cfg_d.overwrite = cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rows_a    <= DIM_W'(1);
      cfg_q.cols_a    <= DIM_W'(1);
      cfg_q.rows_b    <= DIM_W'(1);
      cfg_q.cols_b    <= DIM_W'(1);
      cfg_q.overwrite <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // classification of accepted items
  kpe_front #(
    .MAX_DIM_A (MAX_DIM_A),
    .MAX_DIM_B (MAX_DIM_B)
  ) u_front (
    .valid_i (push && !full),
    .item_i  (in_item_i),
    .cfg_i   (cfg_q),
    .push_o  (front_push),
    .item_o  (front_item)
  );

  // queue between front and back
  kpe_fifo #(
    .WIDTH (MID_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_item),
    .full_o  (full),
    .pop_i   (mid_pop),
    .data_o  (mid_data),
    .empty_o (mid_empty)
  );

  // stores and arithmetic
  kpe_back #(
    .MAX_DIM_A (MAX_DIM_A),
    .MAX_DIM_B (MAX_DIM_B)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .overwrite_i (cfg_q.overwrite),
    .mid_empty_i (mid_empty),
    .mid_item_i  (mid_item_t'(mid_data)),
    .mid_pop_o   (mid_pop),
    .res_pop_i   (pop && !empty),
    .res_push_o  (res_push),
    .res_item_o  (res_item)
  );

  // result queue, space is reserved at issue so full is never hit on push
  kpe_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_item),
    .full_o  (res_full),
    .pop_i   (pop && !res_full | pop),
    .data_o  (res_data),
    .empty_o (empty)
  );

  assign out_item_o = out_item_t'(res_data);

endmodule

// File: test/kronecker_product_engine_test.sv
// self-checking testbench for the kronecker product engine with random idling on both sides
module kronecker_product_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  import kpe_pkg::*;

  localparam logic [1:0]        CMD_UNUSED   = 2'd3;
  localparam logic [CFG_IW-1:0] CFG_UNUSED   = 3'd7;
  localparam int                DRAIN_CYCLES = 8;
  localparam int                CYCLE_LIMIT  = 200_000;
  localparam int                A_WORDS      = MAX_DIM_A_DEF * MAX_DIM_A_DEF;
  localparam int                B_WORDS      = MAX_DIM_B_DEF * MAX_DIM_B_DEF;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                push        = 1'b0;
  in_item_t            in_item_i   = '0;
  logic                full;
  logic                empty;
  logic                pop         = 1'b0;
  out_item_t           out_item_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CFG_IW-1:0]   cfg_index_i = '0;
  logic [CFG_DW-1:0]   cfg_data_i  = '0;

  // shadow of the engine: sizes, overwrite flag and both element stores
  cfg_t               cfg_now = '{rows_a: 5'd1, cols_a: 5'd1, rows_b: 5'd1, cols_b: 5'd1,
                                  overwrite: 1'b1};
  logic signed [31:0] a_mem [A_WORDS];
  logic signed [31:0] b_mem [B_WORDS];

  // elements known to be written, tracked while items are queued
  bit a_set [A_WORDS];
  bit b_set [B_WORDS];

  in_item_t  cmd_queue [$];
  out_item_t sums_due  [$];
  bit        item_live  = 1'b0;
  int        idle_pct   = 0;
  int        send_gap   = 0;
  int        pop_stall  = 0;
  int        mismatches = 0;
  int        cycle_count = 0;

  kronecker_product_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .in_item_i   (in_item_i),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic log_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  function automatic int eff_dim(logic [DIM_W-1:0] d, int cap);
    return (d > cap) ? cap : int'(d);
  endfunction

  function automatic bit a_ok(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
    return r < cfg_now.rows_a && r < MAX_DIM_A_DEF && c < cfg_now.cols_a && c < MAX_DIM_A_DEF;
  endfunction

  function automatic bit b_ok(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
    return r < cfg_now.rows_b && r < MAX_DIM_B_DEF && c < cfg_now.cols_b && c < MAX_DIM_B_DEF;
  endfunction

  // apply one accepted item to the shadow and queue the result element it produces
  function automatic void predict_element(in_item_t it);
    int unsigned        ka;
    int unsigned        kb;
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] prod;
    logic signed [63:0] base;
    logic signed [63:0] total;
    out_item_t          res;
    ka = it.a_row * MAX_DIM_A_DEF + it.a_col;
    kb = it.b_row * MAX_DIM_B_DEF + it.b_col;
    case (it.cmd)
      CMD_WR_A: if (a_ok(it.a_row, it.a_col)) a_mem[ka] = it.value;
      CMD_WR_B: if (b_ok(it.b_row, it.b_col)) b_mem[kb] = it.value;
      CMD_COMPUTE: begin
        if (!a_ok(it.a_row, it.a_col) || !b_ok(it.b_row, it.b_col)) begin
          res.sum    = '0;
          res.status = STATUS_INDEX;
        end else begin
          x          = 64'(a_mem[ka]);
          y          = 64'(b_mem[kb]);
          prod       = x * y;
          base       = cfg_now.overwrite ? 64'sd0 : it.prior;
          total      = base + prod;
          res.status = STATUS_OK;
          // same signs in, other sign out: clamp
          if (!base[63] && !prod[63] && total[63]) begin
            total      = {1'b0, {63{1'b1}}};
            res.status = STATUS_SAT;
          end else if (base[63] && prod[63] && !total[63]) begin
            total      = {1'b1, 63'd0};
            res.status = STATUS_SAT;
          end
          res.sum = total;
        end
        sums_due.push_back(res);
      end
      default: ;
    endcase
  endfunction

  // driver: keeps push up until the item is taken, random gap bursts in between
  always @(posedge clk_i) begin
    logic     push_n;
    in_item_t item_n;
    push_n = push;
    item_n = in_item_i;
    if (rst_ni) begin
      if (push && !full) begin
        predict_element(in_item_i);
        item_live = 1'b0;
        push_n    = 1'b0;
      end
      if (!push_n) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
          send_gap = $urandom_range(1, 5) - 1;
        end else if (cmd_queue.size() > 0) begin
          item_n    = cmd_queue.pop_front();
          push_n    = 1'b1;
          item_live = 1'b1;
        end
      end
    end
    push      <= push_n;
    in_item_i <= item_n;
  end

  // monitor: checks each result item against the oldest expected one
  always @(posedge clk_i) begin
    logic      pop_n;
    out_item_t want;
    pop_n = 1'b0;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (sums_due.size() == 0) begin
          log_mismatch($sformatf("unexpected result sum=%h status=%0d",
                                 out_item_o.sum, out_item_o.status));
        end else begin
          want = sums_due.pop_front();
          if (out_item_o.sum !== want.sum)
            log_mismatch($sformatf("sum %h, expected %h", out_item_o.sum, want.sum));
          if (out_item_o.status !== want.status)
            log_mismatch($sformatf("status %0d, expected %0d", out_item_o.status, want.status));
        end
      end
      pop_n = 1'b1;
      if (pop_stall > 0) begin
        pop_stall--;
        pop_n = 1'b0;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        pop_stall = $urandom_range(1, 5) - 1;
        pop_n     = 1'b0;
      end
    end
    pop <= pop_n;
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_ROWS_A:    cfg_now.rows_a    = data;
      CFG_COLS_A:    cfg_now.cols_a    = data;
      CFG_ROWS_B:    cfg_now.rows_b    = data;
      CFG_COLS_B:    cfg_now.cols_b    = data;
      CFG_OVERWRITE: cfg_now.overwrite = data[0];
      default: ;
    endcase
  endtask

  task automatic set_dims(int ra, int ca, int rb, int cb, logic [CFG_DW-1:0] ow_data);
    write_reg(CFG_ROWS_A, CFG_DW'(ra));
    write_reg(CFG_COLS_A, CFG_DW'(ca));
    write_reg(CFG_ROWS_B, CFG_DW'(rb));
    write_reg(CFG_COLS_B, CFG_DW'(cb));
    write_reg(CFG_OVERWRITE, ow_data);
  endtask

  // wait until the engine has nothing left, then let the pipeline run dry
  task automatic settle();
    while (cmd_queue.size() > 0 || item_live || sums_due.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_item(logic [1:0] cmd, logic [IDX_W-1:0] ar, logic [IDX_W-1:0] ac,
                            logic [IDX_W-1:0] br, logic [IDX_W-1:0] bc,
                            logic [31:0] value, logic [63:0] prior);
    in_item_t it;
    it.cmd   = cmd;
    it.a_row = ar;
    it.a_col = ac;
    it.b_row = br;
    it.b_col = bc;
    it.value = value;
    it.prior = prior;
    if (cmd == CMD_WR_A && a_ok(ar, ac)) a_set[ar * MAX_DIM_A_DEF + ac] = 1'b1;
    if (cmd == CMD_WR_B && b_ok(br, bc)) b_set[br * MAX_DIM_B_DEF + bc] = 1'b1;
    cmd_queue.push_back(it);
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(0, 7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return {{16{w[15]}}, w[15:0]};
      default: return w;
    endcase
  endfunction

  function automatic logic [63:0] pick_prior();
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(0, 7))
      0:       return 64'h7fff_ffff_ffff_ffff;
      1:       return 64'h8000_0000_0000_0000;
      2:       return '0;
      3:       return {{32{w[31]}}, w};
      4:       return {2'b01, w[29:0], $urandom()};
      5:       return {2'b10, w[29:0], $urandom()};
      default: return {w, $urandom()};
    endcase
  endfunction

  // random written element inside the current size of A or of B
  function automatic bit pick_written(bit from_b, output logic [IDX_W-1:0] r,
                                      output logic [IDX_W-1:0] c);
    int unsigned keys [$];
    int          nr;
    int          nc;
    int unsigned k;
    r  = '0;
    c  = '0;
    nr = from_b ? eff_dim(cfg_now.rows_b, MAX_DIM_B_DEF) : eff_dim(cfg_now.rows_a, MAX_DIM_A_DEF);
    nc = from_b ? eff_dim(cfg_now.cols_b, MAX_DIM_B_DEF) : eff_dim(cfg_now.cols_a, MAX_DIM_A_DEF);
    for (int i = 0; i < nr; i++)
      for (int j = 0; j < nc; j++)
        if (from_b ? b_set[i * MAX_DIM_B_DEF + j] : a_set[i * MAX_DIM_A_DEF + j])
          keys.push_back(i * 16 + j);
    if (keys.size() == 0) return 1'b0;
    k = keys[$urandom_range(0, keys.size() - 1)];
    r = IDX_W'(k / 16);
    c = IDX_W'(k % 16);
    return 1'b1;
  endfunction

  // mostly loads and computes on written elements, some bad indexes and unused codes
  task automatic queue_random_item();
    int               sel;
    int               ra;
    int               ca;
    int               rb;
    int               cb;
    logic [IDX_W-1:0] ar;
    logic [IDX_W-1:0] ac;
    logic [IDX_W-1:0] br;
    logic [IDX_W-1:0] bc;
    bit               got_a;
    bit               got_b;
    sel = $urandom_range(0, 99);
    ra  = eff_dim(cfg_now.rows_a, MAX_DIM_A_DEF);
    ca  = eff_dim(cfg_now.cols_a, MAX_DIM_A_DEF);
    rb  = eff_dim(cfg_now.rows_b, MAX_DIM_B_DEF);
    cb  = eff_dim(cfg_now.cols_b, MAX_DIM_B_DEF);
    ar  = IDX_W'($urandom());
    ac  = IDX_W'($urandom());
    br  = IDX_W'($urandom());
    bc  = IDX_W'($urandom());
    if (sel < 28) begin
      if (ra > 0 && ca > 0 && $urandom_range(0, 9) != 0) begin
        ar = IDX_W'($urandom_range(0, ra - 1));
        ac = IDX_W'($urandom_range(0, ca - 1));
      end
      queue_item(CMD_WR_A, ar, ac, br, bc, pick_value(), pick_prior());
    end else if (sel < 56) begin
      if (rb > 0 && cb > 0 && $urandom_range(0, 9) != 0) begin
        br = IDX_W'($urandom_range(0, rb - 1));
        bc = IDX_W'($urandom_range(0, cb - 1));
      end
      queue_item(CMD_WR_B, ar, ac, br, bc, pick_value(), pick_prior());
    end else if (sel < 95) begin
      if ($urandom_range(0, 9) == 0 && !(a_ok(ar, ac) && b_ok(br, bc))) begin
        queue_item(CMD_COMPUTE, ar, ac, br, bc, $urandom(), pick_prior());
      end else if (ra == 0 || ca == 0 || rb == 0 || cb == 0) begin
        // nothing can be valid under these sizes
        queue_item(CMD_COMPUTE, ar, ac, br, bc, $urandom(), pick_prior());
      end else begin
        got_a = pick_written(1'b0, ar, ac);
        got_b = pick_written(1'b1, br, bc);
        if (got_a && got_b)
          queue_item(CMD_COMPUTE, ar, ac, br, bc, $urandom(), pick_prior());
        else if (!got_a)
          queue_item(CMD_WR_A, IDX_W'($urandom_range(0, ra - 1)),
                     IDX_W'($urandom_range(0, ca - 1)), br, bc, pick_value(), pick_prior());
        else
          queue_item(CMD_WR_B, ar, ac, IDX_W'($urandom_range(0, rb - 1)),
                     IDX_W'($urandom_range(0, cb - 1)), pick_value(), pick_prior());
      end
    end else begin
      queue_item(CMD_UNUSED, ar, ac, br, bc, $urandom(), {$urandom(), $urandom()});
    end
  endtask

  // fill both matrices, then one compute per position of the kronecker product
  task automatic queue_kron_pass();
    int ra;
    int ca;
    int rb;
    int cb;
    ra = eff_dim(cfg_now.rows_a, MAX_DIM_A_DEF);
    ca = eff_dim(cfg_now.cols_a, MAX_DIM_A_DEF);
    rb = eff_dim(cfg_now.rows_b, MAX_DIM_B_DEF);
    cb = eff_dim(cfg_now.cols_b, MAX_DIM_B_DEF);
    for (int i = 0; i < ra; i++)
      for (int j = 0; j < ca; j++)
        queue_item(CMD_WR_A, IDX_W'(i), IDX_W'(j), IDX_W'($urandom()), IDX_W'($urandom()),
                   pick_value(), pick_prior());
    for (int i = 0; i < rb; i++)
      for (int j = 0; j < cb; j++)
        queue_item(CMD_WR_B, IDX_W'($urandom()), IDX_W'($urandom()), IDX_W'(i), IDX_W'(j),
                   pick_value(), pick_prior());
    for (int i = 0; i < ra; i++)
      for (int k = 0; k < rb; k++)
        for (int j = 0; j < ca; j++)
          for (int l = 0; l < cb; l++)
            queue_item(CMD_COMPUTE, IDX_W'(i), IDX_W'(j), IDX_W'(k), IDX_W'(l),
                       $urandom(), pick_prior());
  endtask

  task automatic queue_random(int n);
    repeat (n) queue_random_item();
  endtask

  // stimulus
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset sizes: extremes of the operands, bad indexes, unused code
    idle_pct = 20;
    queue_item(CMD_WR_A, 4'd0, 4'd0, 4'd0, 4'd0, 32'h8000_0000, '0);
    queue_item(CMD_WR_B, 4'd0, 4'd0, 4'd0, 4'd0, 32'h8000_0000, '0);
    queue_item(CMD_COMPUTE, 4'd0, 4'd0, 4'd0, 4'd0, '0, 64'h7fff_ffff_ffff_ffff);
    queue_item(CMD_WR_A, 4'd0, 4'd1, 4'd0, 4'd0, 32'h1234_5678, '0);
    queue_item(CMD_COMPUTE, 4'd0, 4'd1, 4'd0, 4'd0, '0, '0);
    queue_item(CMD_COMPUTE, 4'd0, 4'd0, 4'd15, 4'd15, '0, '0);
    queue_item(CMD_UNUSED, 4'hf, 4'hf, 4'hf, 4'hf, '1, '1);
    settle();

    // full sizes, accumulate (upper data bits set, lsb clear)
    set_dims(16, 16, 16, 16, 5'b11110);
    queue_item(CMD_WR_A, 4'd15, 4'd15, 4'd0, 4'd0, 32'h7fff_ffff, '0);
    queue_item(CMD_WR_B, 4'd0, 4'd0, 4'd15, 4'd15, 32'h7fff_ffff, '0);
    queue_item(CMD_COMPUTE, 4'd15, 4'd15, 4'd15, 4'd15, '0, 64'h7fff_ffff_ffff_ffff);
    queue_item(CMD_WR_A, 4'd15, 4'd0, 4'd0, 4'd0, 32'h8000_0000, '0);
    queue_item(CMD_WR_B, 4'd0, 4'd0, 4'd0, 4'd15, 32'h7fff_ffff, '0);
    queue_item(CMD_COMPUTE, 4'd15, 4'd0, 4'd0, 4'd15, '0, 64'h8000_0000_0000_0000);
    queue_item(CMD_COMPUTE, 4'd0, 4'd0, 4'd0, 4'd0, '0, '1);
    queue_item(CMD_COMPUTE, 4'd0, 4'd0, 4'd0, 4'd0, '0, 64'hc000_0000_0000_0000);
    queue_item(CMD_COMPUTE, 4'd0, 4'd0, 4'd0, 4'd0, '0, 64'h4000_0000_0000_0000);
    queue_item(CMD_COMPUTE, 4'd15, 4'd15, 4'd0, 4'd0, '0, 64'h7fff_ffff_ffff_ffff);
    queue_item(CMD_WR_A, 4'd0, 4'd15, 4'd0, 4'd0, '0, '0);
    queue_item(CMD_COMPUTE, 4'd0, 4'd15, 4'd15, 4'd15, '0, 64'h8000_0000_0000_0000);
    settle();

    // full sizes, overwrite; the sender holds off halfway until all results are back
    set_dims(16, 16, 16, 16, 5'b00001);
    queue_random(250);
    settle();
    queue_random(150);
    settle();

    // small matrices, accumulate
    idle_pct = 30;
    set_dims(2, 3, 3, 2, 5'b10100);
    queue_kron_pass();
    queue_random(100);
    settle();

    // single element, no idling
    idle_pct = 0;
    set_dims(1, 1, 1, 1, 5'b00000);
    queue_random(100);
    settle();

    // zero sizes make every index bad
    idle_pct = 10;
    set_dims(0, 5, 0, 7, 5'b00001);
    queue_random(60);
    settle();

    // sizes above the store limit
    idle_pct = 40;
    set_dims(31, 31, 31, 31, 5'b00000);
    queue_random(250);
    settle();

    idle_pct = 15;
    set_dims(17, 4, 16, 9, 5'b00001);
    queue_random(200);
    settle();

    // random sizes, plus a write to an index with no register behind it
    idle_pct = 25;
    set_dims($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 16),
             $urandom_range(1, 16), CFG_DW'($urandom_range(0, 31)));
    write_reg(CFG_UNUSED, CFG_DW'($urandom()));
    queue_random(200);
    settle();

    // closing stretch at full rate
    idle_pct = 0;
    set_dims(3, 2, 2, 3, 5'b11111);
    queue_kron_pass();
    queue_random(250);
    settle();

    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
